/* rtl/stereo_gain_mixer_with_meter_assert.svh */
// Assertion macros for the stereo gain mixer checks.
// Used by the top level; expects clk and rst_n in scope.
`ifndef STEREO_GAIN_MIXER_WITH_METER_ASSERT_SVH
`define STEREO_GAIN_MIXER_WITH_METER_ASSERT_SVH

// Check a condition in the same cycle as its trigger.
`define SGM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sgm: same-cycle check failed");

// Check a condition in the cycle after its trigger.
`define SGM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sgm: next-cycle check failed");

`endif

/* rtl/sgm_pkg.sv */
// Shared constants, widths and types of the stereo gain mixer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package sgm_pkg;

    // channel slots carried on the stream, and how many of them are mixed
    localparam int NCH          = 4;
    localparam int NUM_CHANNELS = 4;
    localparam int METER_WINDOW = 441;

    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 10;
    localparam int LEVEL_W  = 7;
    localparam int SUM_W    = 24;
    localparam int FRAME_W  = 9;

    localparam int NGAIN  = 2 * NCH;
    localparam int GIDX_W = $clog2(NGAIN);

    // signed product of an unsigned gain and a signed sample
    localparam int PROD_W    = GAIN_W + SAMPLE_W + 1;
    localparam int MIX_W     = PROD_W + $clog2(NCH);
    localparam int MIX_SHIFT = 12;
    localparam int QUOT_W    = MIX_W - MIX_SHIFT;
    localparam int MAG_W     = QUOT_W;

    localparam logic signed [SAMPLE_W-1:0] OUT_MAX = 16'sd32767;
    localparam logic signed [SAMPLE_W-1:0] OUT_MIN = -16'sd32767;

    // level = sum / (window * 164), capped; sums beyond the cap all give the top level
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 7'd100;
    localparam int LEVEL_STEP = 164;
    localparam int LEVEL_DIV  = METER_WINDOW * LEVEL_STEP;
    localparam logic [SUM_W-1:0] CAP_SUM = SUM_W'((int'(LEVEL_MAX) + 1) * LEVEL_DIV - 1);
    localparam int CAP_W = $clog2(int'(CAP_SUM) + 1);

    // exact reciprocal: floor(s / LEVEL_DIV) == (s * RECIP_M) >> RECIP_K for s < 2**CAP_W
    localparam int RECIP_K = CAP_W + $clog2(LEVEL_DIV);
    localparam logic [63:0] RECIP_M =
        ((64'd1 << RECIP_K) + 64'(LEVEL_DIV) - 64'd1) / 64'(LEVEL_DIV);
    localparam int RECIP_W    = $clog2(RECIP_M + 64'd1);
    localparam int LVL_PROD_W = CAP_W + RECIP_W;

    // item kinds on tuser
    localparam logic OP_MIX  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam int IN_DATA_W    = ((2 * NCH * SAMPLE_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 2 * SAMPLE_W + 2 * LEVEL_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    // per-stage load strobes from the pipeline control
    typedef struct packed {
        logic load_a;
        logic load_b;
        logic load_c;
        logic load_d;
        logic load_e;
    } pipe_ctl_t;

    // merged frame as it leaves the merge stage
    typedef struct packed {
        logic                       op;
        logic signed [SAMPLE_W-1:0] out_l;
        logic signed [SAMPLE_W-1:0] out_r;
        logic        [MAG_W-1:0]    mag_l;
        logic        [MAG_W-1:0]    mag_r;
    } mix_word_t;

endpackage

`default_nettype wire

/* rtl/sgm_lane.sv */
// One gain lane: registered gain-by-sample product.
// Depends on sgm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sgm_lane
    import sgm_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       load,
    input  wire logic        [GAIN_W-1:0]   gain,
    input  wire logic signed [SAMPLE_W-1:0] sample,
    output logic signed      [PROD_W-1:0]   product
);

    logic signed [PROD_W-1:0] product_reg;
    logic signed [PROD_W-1:0] product_next;

    assign product_next = PROD_W'($signed({1'b0, gain})) * PROD_W'(sample);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            product_reg <= product_next;
        end
    end

    assign product = product_reg;

endmodule

`default_nettype wire

/* rtl/sgm_merge.sv */
// Merge stage: sums lane products per side, divides by 4096 toward zero,
// clamps the output and forms the meter magnitude. Depends on sgm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sgm_merge
    import sgm_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     load,
    input  wire logic                     op,
    input  wire logic signed [PROD_W-1:0] prod_l [NCH],
    input  wire logic signed [PROD_W-1:0] prod_r [NCH],
    output mix_word_t                     word
);

    function automatic logic signed [QUOT_W-1:0] div_trunc(input logic signed [MIX_W-1:0] v);
        logic signed [MIX_W-1:0] adj;
        // bias negatives so the shift rounds toward zero
        adj = v + (v[MIX_W-1] ? MIX_W'((1 << MIX_SHIFT) - 1) : '0);
        return adj[MIX_W-1:MIX_SHIFT];
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] clamp(input logic signed [QUOT_W-1:0] q);
        logic signed [SAMPLE_W-1:0] r;
        if (q > QUOT_W'(OUT_MAX))
            r = OUT_MAX;
        else if (q < QUOT_W'(OUT_MIN))
            r = OUT_MIN;
        else
            r = q[SAMPLE_W-1:0];
        return r;
    endfunction

    function automatic logic [MAG_W-1:0] magnitude(input logic signed [QUOT_W-1:0] q);
        return q[QUOT_W-1] ? MAG_W'(-q) : MAG_W'(q);
    endfunction

    logic signed [MIX_W-1:0]  sum_l;
    logic signed [MIX_W-1:0]  sum_r;
    logic signed [QUOT_W-1:0] quot_l;
    logic signed [QUOT_W-1:0] quot_r;
    mix_word_t                word_next;
    mix_word_t                word_reg;

    always_comb
    begin
        sum_l = '0;
        sum_r = '0;
        for (int ch = 0; ch < NCH; ch++)
        begin
            sum_l = sum_l + MIX_W'(prod_l[ch]);
            sum_r = sum_r + MIX_W'(prod_r[ch]);
        end
        quot_l = div_trunc(sum_l);
        quot_r = div_trunc(sum_r);

        word_next.op = op;
        if (op == OP_TICK)
        begin
            word_next.out_l = '0;
            word_next.out_r = '0;
            word_next.mag_l = '0;
            word_next.mag_r = '0;
        end
        else
        begin
            word_next.out_l = clamp(quot_l);
            word_next.out_r = clamp(quot_r);
            word_next.mag_l = magnitude(quot_l);
            word_next.mag_r = magnitude(quot_r);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= word_next;
        end
    end

    assign word = word_reg;

endmodule

`default_nettype wire

/* rtl/sgm_meter.sv */
// Meter stages: window accumulation, reciprocal level multiply and the
// peak-held level with tick decay; also carries the samples to the output.
// Depends on sgm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sgm_meter
    import sgm_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire pipe_ctl_t            ctl,
    input  wire mix_word_t            word,
    output logic signed [SAMPLE_W-1:0] out_left,
    output logic signed [SAMPLE_W-1:0] out_right,
    output logic        [LEVEL_W-1:0]  level_left,
    output logic        [LEVEL_W-1:0]  level_right
);

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] sum,
                                                 input logic [MAG_W-1:0] mag);
        logic [SUM_W:0] s;
        s = {1'b0, sum} + (SUM_W + 1)'(mag);
        return s[SUM_W] ? '1 : s[SUM_W-1:0];
    endfunction

    function automatic logic [LEVEL_W-1:0] level_of(input logic [SUM_W-1:0] sum);
        logic [CAP_W-1:0]      capped;
        logic [LVL_PROD_W-1:0] prod;
        capped = (sum > CAP_SUM) ? CAP_SUM[CAP_W-1:0] : sum[CAP_W-1:0];
        prod   = LVL_PROD_W'(capped) * LVL_PROD_W'(RECIP_M[RECIP_W-1:0]);
        return prod[RECIP_K +: LEVEL_W];
    endfunction

    // window state
    logic [SUM_W-1:0]   sum_l_reg;
    logic [SUM_W-1:0]   sum_r_reg;
    logic [FRAME_W-1:0] frame_reg;
    logic [SUM_W-1:0]   acc_l_next;
    logic [SUM_W-1:0]   acc_r_next;
    logic [FRAME_W-1:0] frame_next;
    logic               win_end;

    // stage C
    mix_word_t          c_word_reg;
    logic               c_close_reg;
    logic [SUM_W-1:0]   c_sum_l_reg;
    logic [SUM_W-1:0]   c_sum_r_reg;

    // stage D
    logic                       d_op_reg;
    logic                       d_close_reg;
    logic signed [SAMPLE_W-1:0] d_out_l_reg;
    logic signed [SAMPLE_W-1:0] d_out_r_reg;
    logic [LEVEL_W-1:0]         d_lvl_l_reg;
    logic [LEVEL_W-1:0]         d_lvl_r_reg;

    // stage E
    logic signed [SAMPLE_W-1:0] e_out_l_reg;
    logic signed [SAMPLE_W-1:0] e_out_r_reg;
    logic [LEVEL_W-1:0]         held_l_reg;
    logic [LEVEL_W-1:0]         held_r_reg;
    logic [LEVEL_W-1:0]         held_l_next;
    logic [LEVEL_W-1:0]         held_r_next;

    always_comb
    begin
        acc_l_next = sat_add(sum_l_reg, word.mag_l);
        acc_r_next = sat_add(sum_r_reg, word.mag_r);
        frame_next = frame_reg + FRAME_W'(1);
        win_end    = (word.op == OP_MIX) && (frame_next >= FRAME_W'(METER_WINDOW));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_l_reg   <= '0;
            sum_r_reg   <= '0;
            frame_reg   <= '0;
            c_close_reg <= 1'b0;
        end
        else if (ctl.load_c)
        begin
            c_close_reg <= win_end;
            if (word.op == OP_MIX)
            begin
                if (win_end)
                begin
                    sum_l_reg <= '0;
                    sum_r_reg <= '0;
                    frame_reg <= '0;
                end
                else
                begin
                    sum_l_reg <= acc_l_next;
                    sum_r_reg <= acc_r_next;
                    frame_reg <= frame_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_c)
        begin
            c_word_reg  <= word;
            c_sum_l_reg <= acc_l_next;
            c_sum_r_reg <= acc_r_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_op_reg    <= OP_MIX;
            d_close_reg <= 1'b0;
        end
        else if (ctl.load_d)
        begin
            d_op_reg    <= c_word_reg.op;
            d_close_reg <= c_close_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_d)
        begin
            d_out_l_reg <= c_word_reg.out_l;
            d_out_r_reg <= c_word_reg.out_r;
            d_lvl_l_reg <= level_of(c_sum_l_reg);
            d_lvl_r_reg <= level_of(c_sum_r_reg);
        end
    end

    always_comb
    begin
        held_l_next = held_l_reg;
        held_r_next = held_r_reg;
        if (d_op_reg == OP_TICK)
        begin
            if (held_l_reg != '0)
                held_l_next = held_l_reg - LEVEL_W'(1);
            if (held_r_reg != '0)
                held_r_next = held_r_reg - LEVEL_W'(1);
        end
        else if (d_close_reg)
        begin
            if (d_lvl_l_reg > held_l_reg)
                held_l_next = d_lvl_l_reg;
            if (d_lvl_r_reg > held_r_reg)
                held_r_next = d_lvl_r_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_l_reg <= '0;
            held_r_reg <= '0;
        end
        else if (ctl.load_e)
        begin
            held_l_reg <= held_l_next;
            held_r_reg <= held_r_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_e)
        begin
            e_out_l_reg <= d_out_l_reg;
            e_out_r_reg <= d_out_r_reg;
        end
    end

    assign out_left    = e_out_l_reg;
    assign out_right   = e_out_r_reg;
    assign level_left  = held_l_reg;
    assign level_right = held_r_reg;

endmodule

`default_nettype wire

/* rtl/stereo_gain_mixer_with_meter.sv */
// Stereo gain mixer with peak-held level meter: top level, stream ports,
// gain registers and pipeline control. Depends on sgm_pkg, sgm_lane,
// sgm_merge, sgm_meter and stereo_gain_mixer_with_meter_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one word per clock while the input is not back-pressured,
// and returns one result word per input word. Each word passes through the
// stages in order and is presented on the output from the last. The five
// stages are: eight gain lanes (one registered multiplier per channel side),
// the merge (side sums, divide by 4096 toward zero, clamp to +-32767), the
// meter window accumulator, the level multiply (exact reciprocal of
// window*164) and the held-level update with tick decay, which is also the
// output register. Each stage only stalls when it is full and the one after
// it cannot move, so bubbles collapse and the input keeps flowing while a
// result waits on the output, until every stage is full. A tick word returns
// zero samples and the decayed levels. Gains reset to zero; write them only
// while the pipeline is empty. There is no clearing pass after reset.
module stereo_gain_mixer_with_meter
    import sgm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // input stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // in_left_ch0, in_right_ch0, in_left_ch1, in_right_ch1,
    // in_left_ch2, in_right_ch2, in_left_ch3, in_right_ch3 (16 bits each)
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // op: 0 mix, 1 meter tick
    input  wire logic                  s_tuser,
    // output stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // out_left (16), out_right (16), level_left (7), level_right (7), zero pad
    output logic [OUT_DATA_W-1:0]      m_tdata,
    // configuration write port
    input  wire logic                  cfg_we,
    input  wire logic [GIDX_W-1:0]     cfg_index,
    input  wire logic [GAIN_W-1:0]     cfg_data
);

    `include "stereo_gain_mixer_with_meter_assert.svh"

    // gains: even index left, odd index right, per channel
    logic [GAIN_W-1:0] gain_reg [NGAIN];

    // stage valid bits
    logic valid_a_reg, valid_b_reg, valid_c_reg, valid_d_reg, valid_e_reg;
    logic valid_a_next, valid_b_next, valid_c_next, valid_d_next, valid_e_next;
    logic ready_a, ready_b, ready_c, ready_d, ready_e;
    pipe_ctl_t ctl;

    // every stage holds a word
    logic pipe_full;

    logic a_op_reg;

    logic signed [PROD_W-1:0] prod_l [NCH];
    logic signed [PROD_W-1:0] prod_r [NCH];
    mix_word_t                word;

    logic signed [SAMPLE_W-1:0] out_left;
    logic signed [SAMPLE_W-1:0] out_right;
    logic [LEVEL_W-1:0]         level_left;
    logic [LEVEL_W-1:0]         level_right;

    // Configuration: take the write at once, ignore indexes past the list.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NGAIN; i++)
                gain_reg[i] <= '0;
        end
        else if (cfg_we && (int'(cfg_index) < NGAIN))
        begin
            gain_reg[cfg_index] <= cfg_data;
        end
    end

    // Pipeline control: a stage may load when it is empty or its word moves on.
    always_comb
    begin
        ready_e = !valid_e_reg || m_tready;
        ready_d = !valid_d_reg || ready_e;
        ready_c = !valid_c_reg || ready_d;
        ready_b = !valid_b_reg || ready_c;
        ready_a = !valid_a_reg || ready_b;

        ctl.load_a = s_tvalid    && ready_a;
        ctl.load_b = valid_a_reg && ready_b;
        ctl.load_c = valid_b_reg && ready_c;
        ctl.load_d = valid_c_reg && ready_d;
        ctl.load_e = valid_d_reg && ready_e;

        valid_a_next = ready_a ? s_tvalid    : valid_a_reg;
        valid_b_next = ready_b ? valid_a_reg : valid_b_reg;
        valid_c_next = ready_c ? valid_b_reg : valid_c_reg;
        valid_d_next = ready_d ? valid_c_reg : valid_d_reg;
        valid_e_next = ready_e ? valid_d_reg : valid_e_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
            valid_d_reg <= 1'b0;
            valid_e_reg <= 1'b0;
        end
        else
        begin
            valid_a_reg <= valid_a_next;
            valid_b_reg <= valid_b_next;
            valid_c_reg <= valid_c_next;
            valid_d_reg <= valid_d_next;
            valid_e_reg <= valid_e_next;
        end
    end

    // Hold the item kind alongside the lane products.
    always_ff @(posedge clk)
    begin
        if (ctl.load_a)
        begin
            a_op_reg <= s_tuser;
        end
    end

    // Gain lanes: one multiplier per channel side; unmixed channels read as zero.
    for (genvar ch = 0; ch < NCH; ch++)
    begin : g_ch
        if (ch < NUM_CHANNELS)
        begin : g_live
            sgm_lane u_lane_l (
                .clk     (clk),
                .load    (ctl.load_a),
                .gain    (gain_reg[2 * ch]),
                .sample  ($signed(s_tdata[(2 * ch) * SAMPLE_W +: SAMPLE_W])),
                .product (prod_l[ch])
            );
            sgm_lane u_lane_r (
                .clk     (clk),
                .load    (ctl.load_a),
                .gain    (gain_reg[2 * ch + 1]),
                .sample  ($signed(s_tdata[(2 * ch + 1) * SAMPLE_W +: SAMPLE_W])),
                .product (prod_r[ch])
            );
        end
        else
        begin : g_idle
            assign prod_l[ch] = '0;
            assign prod_r[ch] = '0;
        end
    end

    // Merge the lanes into one stereo frame.
    sgm_merge u_merge (
        .clk    (clk),
        .load   (ctl.load_b),
        .op     (a_op_reg),
        .prod_l (prod_l),
        .prod_r (prod_r),
        .word   (word)
    );

    // Meter window, level and held levels; drives the output register.
    sgm_meter u_meter (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .word        (word),
        .out_left    (out_left),
        .out_right   (out_right),
        .level_left  (level_left),
        .level_right (level_right)
    );

    assign s_tready = ready_a;
    assign m_tvalid = valid_e_reg;
    assign m_tdata  = {(OUT_DATA_W - OUT_FIELDS_W)'(0), level_right, level_left,
                       out_right, out_left};

    assign pipe_full = valid_a_reg && valid_b_reg && valid_c_reg && valid_d_reg
                       && valid_e_reg;

    // Input back-pressure only when every stage is full and the output stalls.
    `SGM_ASSERT_NOW(a_stall_only_when_full, !s_tready, pipe_full && !m_tready)
    // An accepted word occupies the first stage next cycle.
    `SGM_ASSERT_NEXT(a_accept_fills_a, s_tvalid && s_tready, valid_a_reg)
    // Held levels move only when a word enters the output stage.
    `SGM_ASSERT_NEXT(a_level_moves_on_load, !ctl.load_e, $stable(level_left) && $stable(level_right))
    // Levels shown on the output never pass the top of the scale.
    `SGM_ASSERT_NOW(a_level_in_range, m_tvalid, level_left <= LEVEL_MAX && level_right <= LEVEL_MAX)

endmodule

`default_nettype wire

/* verif/stereo_gain_mixer_with_meter_tb.sv */
// Self-checking testbench for stereo_gain_mixer_with_meter: random and directed
// mix and tick words, with a scoreboard that predicts samples and meter levels.
// Depends on sgm_pkg and the block's RTL only.
`timescale 1ns / 1ps

module stereo_gain_mixer_with_meter_tb;
    import sgm_pkg::*;

    // Stimulus shaping
    typedef enum {SAMPLE_FULL, SAMPLE_LOUD, SAMPLE_QUIET} sample_style_e;
    typedef enum {GAINS_MAX, GAINS_ZERO, GAINS_RANDOM, GAINS_EXTREME} gain_plan_e;

    // Gain register indexes, in the order of the configuration map
    typedef enum logic [GIDX_W-1:0] {
        REG_GAIN_LEFT_CH0  = 3'd0,
        REG_GAIN_RIGHT_CH0 = 3'd1,
        REG_GAIN_LEFT_CH1  = 3'd2,
        REG_GAIN_RIGHT_CH1 = 3'd3,
        REG_GAIN_LEFT_CH2  = 3'd4,
        REG_GAIN_RIGHT_CH2 = 3'd5,
        REG_GAIN_LEFT_CH3  = 3'd6,
        REG_GAIN_RIGHT_CH3 = 3'd7
    } gain_reg_e;

    localparam gain_reg_e GAIN_REGS [NGAIN] = '{
        REG_GAIN_LEFT_CH0, REG_GAIN_RIGHT_CH0, REG_GAIN_LEFT_CH1, REG_GAIN_RIGHT_CH1,
        REG_GAIN_LEFT_CH2, REG_GAIN_RIGHT_CH2, REG_GAIN_LEFT_CH3, REG_GAIN_RIGHT_CH3
    };

    localparam logic [SAMPLE_W-1:0] S_MAX  = 16'h7FFF;
    localparam logic [SAMPLE_W-1:0] S_MIN  = 16'h8000;
    localparam logic [SAMPLE_W-1:0] S_ZERO = 16'h0000;

    localparam logic [GAIN_W-1:0] GAIN_TOP = 10'd1023;

    // Receiver hold-off: stall the output this long after this many words
    localparam int HOLD_AFTER  = 800;
    localparam int HOLD_CYCLES = 100;

    localparam int unsigned CYCLE_LIMIT = 400000;

    typedef struct {
        logic signed [SAMPLE_W-1:0] out_l;
        logic signed [SAMPLE_W-1:0] out_r;
        logic        [LEVEL_W-1:0]  lvl_l;
        logic        [LEVEL_W-1:0]  lvl_r;
    } mix_result_t;

    // Mixer and meter predictor plus the queue of results still owed by the block
    class mix_meter_board;
        localparam longint MIX_DIV     = 4096;
        localparam longint CLAMP_LIMIT = 32767;
        localparam longint SUM_CEIL    = 64'd16777215;
        localparam int     WINDOW_DIV  = METER_WINDOW * 164;
        localparam int     METER_CAP   = 100;

        logic [GAIN_W-1:0] gain [NGAIN];
        longint            sum_l, sum_r;
        int                frames;
        int                held_l, held_r;
        mix_result_t       pending_mixes[$];
        int                mismatches;

        function new();
            foreach (gain[i]) gain[i] = '0;
            sum_l = 0;
            sum_r = 0;
            frames = 0;
            held_l = 0;
            held_r = 0;
            mismatches = 0;
        endfunction

        function int pending();
            return pending_mixes.size();
        endfunction

        // add the magnitude of the unclamped quotient, saturating at 24 bits
        function longint accumulate(longint sum, longint q);
            longint s;
            s = sum + (q < 0 ? -q : q);
            return (s > SUM_CEIL) ? SUM_CEIL : s;
        endfunction

        function logic signed [SAMPLE_W-1:0] clamp(longint q);
            if (q > CLAMP_LIMIT) return SAMPLE_W'(CLAMP_LIMIT);
            if (q < -CLAMP_LIMIT) return SAMPLE_W'(-CLAMP_LIMIT);
            return SAMPLE_W'(q);
        endfunction

        function int window_level(longint sum, int held);
            int lv;
            lv = int'(sum / WINDOW_DIV);
            if (lv > METER_CAP) lv = METER_CAP;
            return (lv > held) ? lv : held;
        endfunction

        // Predict the result of one accepted input word
        function void note_frame(logic op, logic [IN_DATA_W-1:0] data);
            longint      acc_l, acc_r;
            mix_result_t r;
            acc_l = 0;
            acc_r = 0;
            if (op == OP_TICK) begin
                if (held_l > 0) held_l--;
                if (held_r > 0) held_r--;
                r.out_l = '0;
                r.out_r = '0;
            end
            else begin
                for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
                    acc_l += longint'(gain[2 * ch])
                           * longint'($signed(data[(2 * ch) * SAMPLE_W +: SAMPLE_W]));
                    acc_r += longint'(gain[2 * ch + 1])
                           * longint'($signed(data[(2 * ch + 1) * SAMPLE_W +: SAMPLE_W]));
                end
                // signed division truncates toward zero
                acc_l = acc_l / MIX_DIV;
                acc_r = acc_r / MIX_DIV;
                sum_l = accumulate(sum_l, acc_l);
                sum_r = accumulate(sum_r, acc_r);
                r.out_l = clamp(acc_l);
                r.out_r = clamp(acc_r);
                frames = (frames + 1) % 512;
                if (frames >= METER_WINDOW) begin
                    held_l = window_level(sum_l, held_l);
                    held_r = window_level(sum_r, held_r);
                    sum_l = 0;
                    sum_r = 0;
                    frames = 0;
                end
            end
            r.lvl_l = LEVEL_W'(held_l);
            r.lvl_r = LEVEL_W'(held_r);
            pending_mixes.push_back(r);
        endfunction

        // Compare one accepted output word against the oldest prediction
        function void check_word(logic [OUT_DATA_W-1:0] word);
            mix_result_t                exp_r;
            logic signed [SAMPLE_W-1:0] got_l, got_r;
            logic        [LEVEL_W-1:0]  got_ll, got_lr;
            got_l  = word[SAMPLE_W-1:0];
            got_r  = word[2*SAMPLE_W-1:SAMPLE_W];
            got_ll = word[2*SAMPLE_W +: LEVEL_W];
            got_lr = word[2*SAMPLE_W + LEVEL_W +: LEVEL_W];
            if (pending_mixes.size() == 0) begin
                $error("result word %h with no input word pending", word);
                mismatches++;
                return;
            end
            exp_r = pending_mixes.pop_front();
            if (got_l !== exp_r.out_l) begin
                $error("out_left: expected %0d, got %0d", exp_r.out_l, got_l);
                mismatches++;
            end
            if (got_r !== exp_r.out_r) begin
                $error("out_right: expected %0d, got %0d", exp_r.out_r, got_r);
                mismatches++;
            end
            if (got_ll !== exp_r.lvl_l) begin
                $error("level_left: expected %0d, got %0d", exp_r.lvl_l, got_ll);
                mismatches++;
            end
            if (got_lr !== exp_r.lvl_r) begin
                $error("level_right: expected %0d, got %0d", exp_r.lvl_r, got_lr);
                mismatches++;
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_we;
    logic [GIDX_W-1:0]     cfg_index;
    logic [GAIN_W-1:0]     cfg_data;

    mix_meter_board board;

    // Idle pacing: every 64 words each side redraws whether it runs without gaps
    int  send_left = 0;
    bit  send_calm = 1'b0;
    int  take_left = 0;
    bit  take_calm = 1'b0;
    int  words_taken = 0;
    int unsigned cycle_count = 0;

    stereo_gain_mixer_with_meter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: end the run as failed once the cycle count reaches its limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Same left and right sample on every channel slot
    function automatic logic [IN_DATA_W-1:0] all_channels(logic [SAMPLE_W-1:0] l,
                                                          logic [SAMPLE_W-1:0] r);
        logic [IN_DATA_W-1:0] data;
        data = '0;
        for (int ch = 0; ch < NCH; ch++)
        begin
            data[(2 * ch) * SAMPLE_W +: SAMPLE_W]     = l;
            data[(2 * ch + 1) * SAMPLE_W +: SAMPLE_W] = r;
        end
        return data;
    endfunction

    // One channel driven, the rest silent
    function automatic logic [IN_DATA_W-1:0] one_channel(int ch, logic [SAMPLE_W-1:0] l,
                                                         logic [SAMPLE_W-1:0] r);
        logic [IN_DATA_W-1:0] data;
        data = '0;
        data[(2 * ch) * SAMPLE_W +: SAMPLE_W]     = l;
        data[(2 * ch + 1) * SAMPLE_W +: SAMPLE_W] = r;
        return data;
    endfunction

    function automatic logic [IN_DATA_W-1:0] random_samples(sample_style_e style);
        logic [IN_DATA_W-1:0] data;
        bit                   neg;
        int                   mag;
        data = '0;
        // loud frames share one sign so the meter sum climbs fast toward the cap
        neg = bit'($urandom_range(0, 1));
        for (int k = 0; k < 2 * NCH; k++)
        begin
            case (style)
                SAMPLE_LOUD:
                begin
                    mag = $urandom_range(24000, 32767);
                    data[k * SAMPLE_W +: SAMPLE_W] = neg ? SAMPLE_W'(-mag) : SAMPLE_W'(mag);
                end
                SAMPLE_QUIET:
                    data[k * SAMPLE_W +: SAMPLE_W] = SAMPLE_W'($urandom_range(0, 512) - 256);
                default:
                    data[k * SAMPLE_W +: SAMPLE_W] = SAMPLE_W'($urandom_range(0, 65535));
            endcase
        end
        return data;
    endfunction

    // Offer one word and hold it until accepted; keep tvalid high across
    // back-to-back words so it never drops and rises in the same step
    task automatic send_word(input logic op, input logic [IN_DATA_W-1:0] data);
        int gap;
        if (send_left == 0)
        begin
            send_calm = ($urandom_range(0, 2) == 0);
            send_left = 64;
        end
        send_left--;
        gap = send_calm ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= data;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        board.note_frame(op, data);
    endtask

    // Drop valid and wait until every predicted result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
    endtask

    // Write all eight gains back to back; call only with the pipeline empty
    task automatic program_gains(input gain_plan_e plan);
        logic [GAIN_W-1:0] g;
        for (int i = 0; i < NGAIN; i++)
        begin
            case (plan)
                GAINS_MAX:     g = GAIN_TOP;
                GAINS_ZERO:    g = '0;
                GAINS_EXTREME: g = ($urandom_range(0, 1) != 0) ? GAIN_TOP : '0;
                default:       g = GAIN_W'($urandom_range(0, 1023));
            endcase
            cfg_we    <= 1'b1;
            cfg_index <= GAIN_REGS[i];
            cfg_data  <= g;
            @(posedge clk);
            board.gain[GAIN_REGS[i]] = g;
        end
        cfg_we <= 1'b0;
    endtask

    task automatic run_random(input int count, input sample_style_e style,
                              input int tick_pct);
        logic op;
        for (int n = 0; n < count; n++)
        begin
            op = ($urandom_range(1, 100) <= tick_pct) ? OP_TICK : OP_MIX;
            send_word(op, random_samples(style));
        end
    endtask

    // Receiver: take result words with random stalls, and one long hold-off
    // that backs the pipeline up into the input while the sender keeps offering
    initial
    begin
        int gap;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (take_left == 0)
            begin
                take_calm = ($urandom_range(0, 2) == 0);
                take_left = 64;
            end
            take_left--;
            gap = take_calm ? 0 : $urandom_range(0, 12);
            if (words_taken == HOLD_AFTER) gap = HOLD_CYCLES;
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
            board.check_word(m_tdata);
            words_taken++;
        end
    end

    // Main sequence
    initial
    begin
        board     = new();
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_MIX;
        m_tready  = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_GAIN_LEFT_CH0;
        cfg_data  = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Gains still at their reset value: full-scale input must mix to silence
        send_word(OP_MIX, all_channels(S_MAX, S_MIN));
        // tick with held levels already at zero: levels stay at zero
        send_word(OP_TICK, all_channels(S_MIN, S_MAX));
        drain();

        // Directed words at the top gain on every side
        program_gains(GAINS_MAX);
        send_word(OP_MIX, all_channels(S_MAX, S_MAX));
        send_word(OP_MIX, all_channels(S_MIN, S_MIN));
        send_word(OP_MIX, all_channels(S_MAX, S_MIN));
        send_word(OP_MIX, all_channels(S_ZERO, S_ZERO));
        // small quotients: check truncation toward zero on both signs
        send_word(OP_MIX, one_channel(0, -16'sd5, 16'sd5));
        send_word(OP_MIX, one_channel(0, -16'sd1, 16'sd1));
        send_word(OP_MIX, one_channel(1, S_MIN, S_MAX));
        send_word(OP_MIX, one_channel(2, 16'sd4096, -16'sd4096));
        send_word(OP_MIX, one_channel(3, S_MAX, S_MIN));
        send_word(OP_MIX, all_channels(16'h5555, 16'hAAAA));
        send_word(OP_MIX, all_channels(16'hAAAA, 16'h5555));
        // tick words carry loud samples that must be ignored
        send_word(OP_TICK, all_channels(S_MAX, S_MAX));
        send_word(OP_TICK, all_channels(S_MIN, S_MIN));

        // Loud window: drive the level to its cap
        run_random(460, SAMPLE_LOUD, 0);
        // Tick run: decay the held levels all the way down and past zero
        run_random(110, SAMPLE_FULL, 100);
        drain();

        // Random gains, full-range samples; the long output hold lands here
        program_gains(GAINS_RANDOM);
        run_random(400, SAMPLE_FULL, 10);
        drain();

        program_gains(GAINS_EXTREME);
        run_random(250, SAMPLE_FULL, 5);
        drain();

        program_gains(GAINS_ZERO);
        run_random(60, SAMPLE_FULL, 10);
        drain();

        program_gains(GAINS_RANDOM);
        run_random(100, SAMPLE_QUIET, 10);
        drain();

        // let any stray words out before judging
        repeat (10) @(posedge clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
